// ===== hw/rtl/pipt_pkg.sv =====
// Shared constants and controller/datapath interface types for the point-in-polygon test.
package pipt_pkg;

  localparam int COORD_BITS = 32;
  localparam int VTX_DEPTH  = 64;
  localparam int IDX_W      = $clog2(VTX_DEPTH);
  localparam int CNT_W      = $clog2(VTX_DEPTH + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  localparam logic [CNT_W-1:0] MIN_VERTS = CNT_W'(3);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_VCOUNT = 1'b0;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             rd_en;
    logic             rd_edge;
    logic [IDX_W-1:0] rd_addr;
    logic             emit;
    logic             few;
  } pipt_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } pipt_sts_t;

endpackage

// ===== hw/rtl/pipt_ctrl.sv =====
// Sequencer for vertex loads and the edge walk of a query.
module pipt_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_action,
  output logic                      in_ready,
  input  logic [pipt_pkg::CNT_W-1:0] vcount,
  output pipt_pkg::pipt_cmd_t       cmd,
  input  pipt_pkg::pipt_sts_t       sts
);
  import pipt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] rd_cnt_next;
  logic             few;
  logic             few_next;
  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] rd_cnt_m1;
  logic             few_now;
  logic             accept;

  // Clamp the vertex count to the store depth
  assign n_sat     = (vcount > CNT_W'(VTX_DEPTH)) ? CNT_W'(VTX_DEPTH) : vcount;
  assign n_m1      = n_sat - 1'b1;
  assign rd_cnt_m1 = rd_cnt - 1'b1;
  assign few_now   = n_sat < MIN_VERTS;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  // Drive commands: first read primes the closing vertex, later reads form edges
  always_comb begin
    cmd.load    = accept && (in_action == ACT_LOAD);
    cmd.start   = accept && (in_action == ACT_QUERY) && !few_now;
    cmd.rd_en   = (state == S_RUN);
    cmd.rd_edge = (state == S_RUN) && (rd_cnt != '0);
    cmd.rd_addr = (rd_cnt == '0) ? n_m1[IDX_W-1:0] : rd_cnt_m1[IDX_W-1:0];
    cmd.emit    = (state == S_FIN) && sts.out_free;
    cmd.few     = few;
  end

  // Advance the sequencer
  always_comb begin
    state_next  = state;
    rd_cnt_next = rd_cnt;
    few_next    = few;
    case (state)
      S_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          few_next    = few_now;
          rd_cnt_next = '0;
          state_next  = few_now ? S_FIN : S_RUN;
        end
      end
      S_RUN: begin
        rd_cnt_next = rd_cnt + 1'b1;
        if (rd_cnt == n_sat) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_cnt <= '0;
      few    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_cnt <= rd_cnt_next;
      few    <= few_next;
    end
  end

  // A result leaves only once the edge pipeline has emptied
  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.busy)
    else $error("result emitted with edges still in flight");

  // A degenerate polygon skips the edge walk
  a_few_to_fin: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_action == ACT_QUERY) && few_now) |=> (state == S_FIN))
    else $error("short polygon did not go straight to result");

endmodule

// ===== hw/rtl/pipt_dp.sv =====
// Vertex store, edge crossing pipeline, parity flag and result register.
module pipt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pipt_pkg::pipt_cmd_t                 cmd,
  output pipt_pkg::pipt_sts_t                 sts,
  input  logic [pipt_pkg::IDX_W-1:0]          in_index,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [pipt_pkg::COORD_BITS-1:0] in_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_inside,
  output logic                                out_few
);
  import pipt_pkg::*;

  logic signed [COORD_BITS-1:0] mem_x [VTX_DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [VTX_DEPTH];

  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;
  logic                         rdv;
  logic                         rd_edge_q;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;

  logic signed [DIFF_W-1:0] a_d;
  logic signed [DIFF_W-1:0] dy_d;
  logic signed [DIFF_W-1:0] b_d;
  logic signed [DIFF_W-1:0] c_d;
  logic                     hit_d;
  logic                     dy_pos_d;
  logic                     dv;

  logic signed [PROD_W-1:0] lp_m;
  logic signed [PROD_W-1:0] rp_m;
  logic                     hit_m;
  logic                     dy_pos_m;
  logic                     mv;

  logic parity;
  logic left;

  // Store loads; registered read for the edge walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_x[in_index] <= in_x;
      mem_y[in_index] <= in_y;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[cmd.rd_addr];
      rd_y <= mem_y[cmd.rd_addr];
    end
  end

  // Hold the query point
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pt_x <= in_x;
      pt_y <= in_y;
    end
  end

  // Difference stage: vertex i is the fresh read, vertex j the one before it
  always_ff @(posedge clk) begin
    if (rdv) begin
      prev_x   <= rd_x;
      prev_y   <= rd_y;
      a_d      <= DIFF_W'(pt_x) - DIFF_W'(rd_x);
      dy_d     <= DIFF_W'(prev_y) - DIFF_W'(rd_y);
      b_d      <= DIFF_W'(prev_x) - DIFF_W'(rd_x);
      c_d      <= DIFF_W'(pt_y) - DIFF_W'(rd_y);
      hit_d    <= rd_edge_q && ((rd_y > pt_y) != (prev_y > pt_y));
      dy_pos_d <= prev_y > rd_y;
    end
  end

  // Product stage: both sides of the cross-multiplied crossing test
  always_ff @(posedge clk) begin
    if (dv) begin
      lp_m     <= a_d * dy_d;
      rp_m     <= b_d * c_d;
      hit_m    <= hit_d;
      dy_pos_m <= dy_pos_d;
    end
  end

  // Compare with the direction set by the sign of dy
  assign left = dy_pos_m ? (lp_m < rp_m) : (rp_m < lp_m);

  // Advance stage valids and toggle the parity flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rdv    <= 1'b0;
      dv     <= 1'b0;
      mv     <= 1'b0;
      parity <= 1'b0;
    end else begin
      rdv <= cmd.rd_en;
      dv  <= rdv;
      mv  <= dv;
      if (cmd.start) begin
        parity <= 1'b0;
      end else if (mv && hit_m && left) begin
        parity <= !parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_edge_q <= cmd.rd_edge;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_inside <= cmd.few ? 1'b0 : parity;
      out_few    <= cmd.few;
    end
  end

  assign sts.busy     = rdv || dv || mv;
  assign sts.out_free = !out_valid || out_ready;

  // A degenerate polygon never reports inside
  a_few_outside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_few) |-> !out_inside)
    else $error("inside reported for polygon with too few vertices");

  // Parity flag only moves while edges are in flight or when a query starts
  a_inside_quiet: assert property (@(posedge clk) disable iff (rst)
    (!mv && !cmd.start) |=> $stable(parity))
    else $error("parity flag changed with no edge in flight");

endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// Top level: stream ports, register port, vertex count register, controller and datapath.
//
//  channel  | dir | handshake        | content
//  ---------+-----+------------------+----------------------------------------------
//  s_*      | in  | s_tvalid/tready  | vertex load (action 0) or query point (1)
//  m_*      | out | m_tvalid/tready  | one result per query
//  p*       | in  | psel/penable     | vertex_count register at byte address 0
//
// A query with n vertices in use (n clamped to 64) reads one vertex per cycle from
// the vertex store, closing vertex first, then drains the difference, product and
// compare stages and posts its result. With fewer than three vertices a query skips
// the edge walk and goes straight to posting.
// Reset clears the control state and the vertex count; the vertex store is not cleared.
// A query may be accepted while the previous result waits; it holds before posting
// until the result register is free.
module point_in_polygon_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // vertex_index[5:0], coord_x[37:6], coord_y[69:38], zero[71:70]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // inside_res[0], too_few_vertices[1], zero[7:2]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pipt_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  pipt_cmd_t        cmd;
  pipt_sts_t        sts;
  logic             out_inside;
  logic             out_few;

  assign pready = 1'b1;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VCOUNT)) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_VCOUNT) ? {{(32-CNT_W){1'b0}}, vertex_count} : 32'd0;

  pipt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .in_ready  (s_tready),
    .vcount    (vertex_count),
    .cmd       (cmd),
    .sts       (sts)
  );

  pipt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_index   (s_tdata[IDX_W-1:0]),
    .in_x       (s_tdata[IDX_W +: COORD_BITS]),
    .in_y       (s_tdata[IDX_W+COORD_BITS +: COORD_BITS]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_inside (out_inside),
    .out_few    (out_few)
  );

  assign m_tdata = {6'd0, out_few, out_inside};

endmodule

// ===== verif/point_in_polygon_test_tb.sv =====
// Self-checking testbench for the even-odd point-in-polygon test block.
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
  import pipt_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 80;        // longer than the longest query
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 500;
  localparam logic [2:0] ADDR_VCOUNT = 3'(4 * REG_VCOUNT);
  localparam logic [2:0] ADDR_SPARE  = 3'd4;  // no register behind it
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic too_few;
    logic inside_res;
  } poly_result_t;

  localparam poly_result_t RES_TOO_FEW = '{too_few: 1'b1, inside_res: 1'b0};

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [5:0]   idx;      // vertex index, or register index for ROW_REG
    logic [31:0]  x;        // write data for ROW_REG
    logic [31:0]  y;
    bit           typed;
    poly_result_t res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // vertex_index[5:0], coord_x[37:6], coord_y[69:38], zero[71:70]
  logic [0:0]  s_tuser = '0;  // action[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // inside_res[0], too_few_vertices[1], zero[7:2]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: vertex store and count register
  logic signed [31:0] vx_mem [VTX_DEPTH];
  logic signed [31:0] vy_mem [VTX_DEPTH];
  logic [CNT_W-1:0]   vcount_model = '0;

  poly_result_t verdict_q [$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  bit  tx_high = 1'b0;
  int  cycle_count = 0;

  // Receiver state
  int          results_taken = 0;
  int          next_hold = 50;
  int          hold_left = 0;
  int          pattern_left = 0;
  int          pattern_pos = 0;
  logic [31:0] ready_mask = '1;
  bit          ready_open = 1'b1;

  point_in_polygon_test uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Even-odd crossing count, exact via cross-multiplication
  function automatic poly_result_t predict_query(logic signed [31:0] px,
                                                 logic signed [31:0] py);
    poly_result_t res;
    int n, j;
    logic signed [31:0] xi, yi, xj, yj;
    logic signed [67:0] ddx, ddy, cx, cy, lhs, rhs;
    logic left;
    res = '0;
    n = (vcount_model > VTX_DEPTH) ? VTX_DEPTH : int'(vcount_model);
    if (n < int'(MIN_VERTS)) begin
      res.too_few = 1'b1;
      return res;
    end
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = vx_mem[i];
      yi = vy_mem[i];
      xj = vx_mem[j];
      yj = vy_mem[j];
      if ((yi > py) != (yj > py)) begin
        ddy = yj - yi;
        ddx = px - xi;
        cx  = xj - xi;
        cy  = py - yi;
        lhs = ddx * ddy;
        rhs = cx * cy;
        left = (ddy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (left) res.inside_res = ~res.inside_res;
      end
      j = i;
    end
    return res;
  endfunction

  function automatic logic [31:0] scaled_coord(int sh);
    logic signed [31:0] raw;
    raw = $urandom;
    return raw >>> sh;
  endfunction

  function automatic plan_row_t mk_row(row_kind_t kind, logic [5:0] idx, logic [31:0] x,
                                       logic [31:0] y, bit typed, poly_result_t res);
    plan_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // Offer one transaction, update the shadow on acceptance, then apply the burst gap
  task automatic send_item(logic action, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           bit typed, poly_result_t typed_res);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {2'b00, y, x, idx};
    tx_high = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (action == ACT_LOAD) begin
      vx_mem[idx] = x;
      vy_mem[idx] = y;
    end else begin
      verdict_q.push_back(typed ? typed_res : predict_query(x, y));
    end
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      tx_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until the block has gone quiet
  task automatic settle();
    if (tx_high) begin
      s_tvalid <= 1'b0;
      tx_high = 1'b0;
    end
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_VCOUNT) vcount_model = data[CNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    poly_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.inside_res = m_tdata[0];
      got.too_few    = m_tdata[1];
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got inside_res %0b too_few %0b",
                 $time, got.inside_res, got.too_few);
      end else begin
        want = verdict_q.pop_front();
        if (got.inside_res !== want.inside_res) begin
          mismatches++;
          $display("%0t: inside_res mismatch, expected %0b, got %0b",
                   $time, want.inside_res, got.inside_res);
        end
        if (got.too_few !== want.too_few) begin
          mismatches++;
          $display("%0t: too_few_vertices mismatch, expected %0b, got %0b",
                   $time, want.too_few, got.too_few);
        end
      end
    end
  end

  // Stall the result side on a changing pattern, with a long hold every few hundred results
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (results_taken >= next_hold) begin
        hold_left = LONG_HOLD;
        next_hold += 400;
        m_tready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 200);
          ready_open = ($urandom_range(0, 3) == 0);
          ready_mask = ($urandom_range(0, 2) == 0) ? ($urandom & $urandom) : $urandom;
        end
        pattern_left--;
        pattern_pos++;
        m_tready <= ready_open ? 1'b1 : ready_mask[pattern_pos % 32];
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    int n, sh, nq, r, k;
    bit first_set;
    logic [31:0] qx, qy, wdata;

    // Directed plan: empty polygon, extreme triangle and square, ignored register
    plan.push_back(mk_row(ROW_QUERY, 6'd0, C_MIN, C_MAX, 1, RES_TOO_FEW));
    plan.push_back(mk_row(ROW_QUERY, 6'd63, C_MAX, C_MIN, 1, RES_TOO_FEW));
    plan.push_back(mk_row(ROW_REG, 6'(REG_VCOUNT), 32'd2, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, '0, '0, 1, RES_TOO_FEW));
    plan.push_back(mk_row(ROW_LOAD, 6'd0, C_MIN, C_MIN, 0, '0));
    plan.push_back(mk_row(ROW_LOAD, 6'd1, C_MAX, C_MIN, 0, '0));
    plan.push_back(mk_row(ROW_LOAD, 6'd2, C_MAX, C_MAX, 0, '0));
    plan.push_back(mk_row(ROW_LOAD, 6'd63, 32'h0001_0000, 32'hFFFF_0000, 0, '0));
    plan.push_back(mk_row(ROW_REG, 6'(REG_VCOUNT), 32'd3, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, '0, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, 32'h4000_0000, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, C_MIN, C_MAX, 0, '0));
    plan.push_back(mk_row(ROW_LOAD, 6'd3, C_MIN, C_MAX, 0, '0));
    plan.push_back(mk_row(ROW_REG, 6'(REG_VCOUNT), 32'd4, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, '0, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, C_MAX, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, C_MIN, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, '0, C_MIN, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, '0, C_MAX, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, C_MAX, C_MAX, 0, '0));
    plan.push_back(mk_row(ROW_REG, 6'(REG_VCOUNT), 32'd1, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, 32'd1, 32'd1, 1, RES_TOO_FEW));
    plan.push_back(mk_row(ROW_REG, 6'd1, 32'd5, '0, 0, '0));
    plan.push_back(mk_row(ROW_QUERY, 6'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1, RES_TOO_FEW));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed plan
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          settle();
          reg_write(3'(4 * plan[i].idx), plan[i].x);
        end
        ROW_LOAD: begin
          send_item(ACT_LOAD, plan[i].idx, plan[i].x, plan[i].y, 0, '0);
        end
        default: begin
          send_item(ACT_QUERY, plan[i].idx, plan[i].x, plan[i].y, plan[i].typed,
                    plan[i].res);
        end
      endcase
    end

    // Random polygons: load vertices, set the count, then run queries against them
    items_sent = 0;
    first_set = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (first_set || r < 5) n = VTX_DEPTH;
      else if (r < 15) n = $urandom_range(0, 2);
      else if (r < 30) n = $urandom_range(9, 20);
      else n = $urandom_range(3, 8);
      case ($urandom_range(0, 3))
        0: sh = 0;
        1: sh = 4;
        2: sh = 12;
        default: sh = 20;
      endcase
      for (int v = 0; v < n; v++) send_item(ACT_LOAD, 6'(v), scaled_coord(sh),
                                            scaled_coord(sh), 0, '0);
      settle();
      // counts above the store depth saturate, so only use them when every entry is loaded
      wdata = n;
      if (first_set) wdata = 32'd127;
      else if (n == VTX_DEPTH && $urandom_range(0, 1) == 1) wdata = $urandom_range(65, 127);
      if ($urandom_range(0, 3) == 0) wdata = {$urandom} & ~32'h7F | (wdata & 32'h7F);
      reg_write(ADDR_VCOUNT, wdata);
      if ($urandom_range(0, 7) == 0) reg_write(ADDR_SPARE, $urandom);
      first_set = 1'b0;

      nq = $urandom_range(10, 40);
      repeat (nq) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_item(ACT_LOAD, 6'($urandom_range(0, 63)), scaled_coord(sh),
                    scaled_coord(sh), 0, '0);
        end else begin
          if (n > 0 && r < 38) begin
            // land on a vertex height, sometimes exactly on the vertex
            k = $urandom_range(0, n - 1);
            qy = vy_mem[k];
            qx = (r < 20) ? vx_mem[k] : scaled_coord(sh);
          end else if (r < 85) begin
            qx = scaled_coord(sh);
            qy = scaled_coord(sh);
          end else begin
            qx = $urandom;
            qy = $urandom;
          end
          send_item(ACT_QUERY, 6'($urandom_range(0, 63)), qx, qy, 0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
